### sv/binary_erosion_3x3_unit_defines.svh
// Assertion macros shared by the binary erosion 3x3 unit modules.
`ifndef BINARY_EROSION_3X3_UNIT_DEFINES_SVH
`define BINARY_EROSION_3X3_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BERO_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence checked at the same edge as the antecedent.
`define BERO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked with non-overlapping implication after the antecedent.
`define BERO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bero_pkg.sv
// Shared constants and types of the binary erosion 3x3 unit.
package bero_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int MAX_HEIGHT    = 512;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W     = 10;
    localparam int OUT_W     = 9;
    localparam int LINE_W    = 2;
    localparam int WIN_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd512;

    // Control carried with one request from the counter stage to the window stage.
    typedef struct packed {
        logic             pix;
        logic             emit;
        logic             last;
        logic             fwd;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bot_ok;
        logic [OUT_W-1:0] er;
        logic [OUT_W-1:0] ec;
    } bero_ctl_t;

endpackage

### sv/bero_ram.sv
// Generic single write port, single read port RAM with registered read.
module bero_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old word on a same-address write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bero_ctrl.sv
// Position counters, configuration registers and line store read issue.
`include "binary_erosion_3x3_unit_defines.svh"

module bero_ctrl #(
    parameter int MAX_WIDTH = bero_pkg::MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int EW = ($clog2(MAX_WIDTH + 1) > bero_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : bero_pkg::CFG_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bero_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bero_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic                           in_pixel,
    input  logic                           s2_fire,
    output logic                           s2_valid,
    output bero_pkg::bero_ctl_t            s2_ctl,
    output logic [AW-1:0]                  s2_addr,
    output logic                           ram_re,
    output logic [AW-1:0]                  ram_raddr
);

    logic [bero_pkg::CFG_W-1:0] image_width_reg, image_width_next;
    logic [bero_pkg::CFG_W-1:0] image_height_reg, image_height_next;
    logic [AW-1:0]              input_col_reg, input_col_next;
    logic [bero_pkg::ROW_W-1:0] input_row_reg, input_row_next;
    logic [AW-1:0]              emit_col_reg, emit_col_next;
    logic [bero_pkg::ROW_W-1:0] emit_row_reg, emit_row_next;
    logic                       s2_valid_reg, s2_valid_next;
    bero_pkg::bero_ctl_t        s2_ctl_reg, s2_ctl_next;
    logic [AW-1:0]              s2_addr_reg;

    logic [EW-1:0]              eff_w;
    logic [bero_pkg::CFG_W-1:0] eff_h;
    logic [EW-1:0]              col_ext;
    logic [EW-1:0]              ecol_ext;
    logic                       accept;
    logic                       col_wrap;
    logic                       ecol_wrap;
    logic                       row_last;
    logic                       emit;

    assign in_stall = s2_valid_reg && !s2_fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (EW'(image_width_reg) > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            eff_h = bero_pkg::CFG_W'(1);
        end
        else if (image_height_reg > bero_pkg::CFG_W'(bero_pkg::MAX_HEIGHT))
        begin
            eff_h = bero_pkg::CFG_W'(bero_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = image_height_reg;
        end
    end

    always_comb
    begin
        col_ext   = EW'(input_col_reg);
        ecol_ext  = EW'(emit_col_reg);
        col_wrap  = (col_ext + EW'(1)) >= eff_w;
        ecol_wrap = (ecol_ext + EW'(1)) >= eff_w;
        row_last  = ({1'b0, emit_row_reg} + 11'd1) >= {1'b0, eff_h};
        emit      = (input_row_reg >= bero_pkg::ROW_W'(2)) ||
                    ((input_row_reg == bero_pkg::ROW_W'(1)) && (input_col_reg != '0));

        s2_ctl_next.pix      = (req_type == bero_pkg::REQ_FLUSH) ? 1'b0 : in_pixel;
        s2_ctl_next.emit     = emit;
        s2_ctl_next.last     = row_last && ecol_wrap;
        s2_ctl_next.fwd      = s2_fire && (s2_addr_reg == input_col_reg);
        s2_ctl_next.left_ok  = (emit_col_reg != '0);
        s2_ctl_next.right_ok = !ecol_wrap;
        s2_ctl_next.top_ok   = (emit_row_reg != '0);
        s2_ctl_next.bot_ok   = !row_last;
        s2_ctl_next.er       = emit_row_reg[bero_pkg::OUT_W-1:0];
        s2_ctl_next.ec       = ecol_ext[bero_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        input_col_next    = input_col_reg;
        input_row_next    = input_row_reg;
        emit_col_next     = emit_col_reg;
        emit_row_next     = emit_row_reg;

        if (cfg_we)
        begin
            // Drop the frame in flight and restart at pixel (0,0).
            case (cfg_index)
                bero_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                bero_pkg::REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default:                    image_width_next  = image_width_reg;
            endcase
            input_col_next = '0;
            input_row_next = '0;
            emit_col_next  = '0;
            emit_row_next  = '0;
        end
        else if (accept)
        begin
            if (emit && s2_ctl_next.last)
            begin
                input_col_next = '0;
                input_row_next = '0;
                emit_col_next  = '0;
                emit_row_next  = '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    input_col_next = '0;
                    input_row_next = input_row_reg + bero_pkg::ROW_W'(1);
                end
                else
                begin
                    input_col_next = input_col_reg + AW'(1);
                end
                if (emit)
                begin
                    if (ecol_wrap)
                    begin
                        emit_col_next = '0;
                        emit_row_next = emit_row_reg + bero_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        emit_col_next = emit_col_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bero_pkg::WIDTH_RESET;
            image_height_reg <= bero_pkg::HEIGHT_RESET;
            input_col_reg    <= '0;
            input_row_reg    <= '0;
            emit_col_reg     <= '0;
            emit_row_reg     <= '0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            input_col_reg    <= input_col_next;
            input_row_reg    <= input_row_next;
            emit_col_reg     <= emit_col_next;
            emit_row_reg     <= emit_row_next;
            s2_valid_reg     <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_ctl_reg  <= s2_ctl_next;
            s2_addr_reg <= input_col_reg;
        end
    end

    assign s2_valid  = s2_valid_reg;
    assign s2_ctl    = s2_ctl_reg;
    assign s2_addr   = s2_addr_reg;
    assign ram_re    = accept;
    assign ram_raddr = input_col_reg;

    `BERO_ASSERT_ALWAYS(a_col_in_row, (EW'(input_col_reg) < eff_w), "input column beyond row")
    `BERO_ASSERT_ALWAYS(a_ecol_in_row, (EW'(emit_col_reg) < eff_w), "emit column beyond row")
    `BERO_ASSERT_NEXT(a_restart_zero, (accept && emit && s2_ctl_next.last && !cfg_we), ((input_col_reg == '0) && (input_row_reg == '0) && (emit_col_reg == '0) && (emit_row_reg == '0)), "counters not cleared at frame end")

endmodule

### sv/bero_win.sv
// 3x3 window, line store write-back, erosion and output register.
`include "binary_erosion_3x3_unit_defines.svh"

module bero_win (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               s2_valid,
    input  bero_pkg::bero_ctl_t                s2_ctl,
    input  logic [bero_pkg::LINE_W-1:0]        ram_rdata,
    output logic                               ram_we,
    output logic [bero_pkg::LINE_W-1:0]        ram_wdata,
    output logic                               s2_fire,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               out_pixel,
    output logic [bero_pkg::OUT_W-1:0]         out_row,
    output logic [bero_pkg::OUT_W-1:0]         out_col,
    output logic                               frame_end
);

    logic [bero_pkg::WIN_W-1:0]  win_reg, win_next;
    logic [bero_pkg::LINE_W-1:0] lw_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_pixel_reg;
    logic [bero_pkg::OUT_W-1:0]  out_row_reg;
    logic [bero_pkg::OUT_W-1:0]  out_col_reg;
    logic                        frame_end_reg;

    logic [bero_pkg::LINE_W-1:0] line;
    logic [bero_pkg::WIN_W-1:0]  win_new;
    logic [bero_pkg::WIN_W-1:0]  mask;
    logic                        res;
    logic                        load;

    // Bit 0 of a line word is the row two above, bit 1 the row just above.
    assign line    = s2_ctl.fwd ? lw_data_reg : ram_rdata;
    assign win_new = {s2_ctl.pix, line, win_reg[bero_pkg::WIN_W-1:3]};

    always_comb
    begin
        mask = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!((k == 1) && (j == 1)) &&
                    !((k == 0) && !s2_ctl.left_ok) && !((k == 2) && !s2_ctl.right_ok) &&
                    !((j == 0) && !s2_ctl.top_ok) && !((j == 2) && !s2_ctl.bot_ok))
                begin
                    mask[k * 3 + j] = 1'b1;
                end
            end
        end
        res = win_new[4] && (&(win_new | ~mask));
    end

    assign s2_fire   = s2_valid && (!s2_ctl.emit || !out_valid_reg || !out_stall);
    assign load      = s2_fire && s2_ctl.emit;
    assign ram_we    = s2_fire;
    assign ram_wdata = {s2_ctl.pix, line[1]};

    always_comb
    begin
        if (cfg_we)
        begin
            win_next = '0;
        end
        else if (s2_fire)
        begin
            win_next = (s2_ctl.emit && s2_ctl.last) ? '0 : win_new;
        end
        else
        begin
            win_next = win_reg;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            lw_data_reg <= ram_wdata;
        end
        if (load)
        begin
            out_pixel_reg <= res;
            out_row_reg   <= s2_ctl.er;
            out_col_reg   <= s2_ctl.ec;
            frame_end_reg <= s2_ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign frame_end = frame_end_reg;

    `BERO_ASSERT_NEXT(a_win_clear, (s2_fire && s2_ctl.emit && s2_ctl.last), (win_reg == '0), "window not cleared after frame end")
    `BERO_ASSERT_NEXT(a_result_shown, load, out_valid_reg, "result loaded but not shown")
    `BERO_ASSERT_SAME(a_no_overwrite, load, (!out_valid_reg || !out_stall), "pending result overwritten")

endmodule

### sv/binary_erosion_3x3_unit.sv
// Output: pixel (r,c) is eroded with the request image_width+1 later, then registered.
// Throughput: one request per cycle unless stalled; each request does one read and one
// write-back of the line store RAM, same-column case forwarded from the previous write.
// Frame: image_width+1 flush requests after the last pixel drain the pending results.
// Reset: counters, window and output valid clear; width and height return to 512.
// The line store RAM is not cleared; never-written entries only feed masked edge taps.
module binary_erosion_3x3_unit #(
    parameter int MAX_WIDTH = bero_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bero_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bero_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic                           in_pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           out_pixel,
    output logic [bero_pkg::OUT_W-1:0]     out_row,
    output logic [bero_pkg::OUT_W-1:0]     out_col,
    output logic                           frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Stage handoff between the counter stage and the window stage.
    logic                        s2_fire;
    logic                        s2_valid;
    bero_pkg::bero_ctl_t         s2_ctl;
    logic [AW-1:0]               s2_addr;

    // Line store port signals: read at request time, write back one stage later.
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [bero_pkg::LINE_W-1:0] ram_rdata;
    logic                        ram_we;
    logic [bero_pkg::LINE_W-1:0] ram_wdata;

    // Track positions, decide emit and frame end, issue the line store read.
    bero_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .in_pixel  (in_pixel),
        .s2_fire   (s2_fire),
        .s2_valid  (s2_valid),
        .s2_ctl    (s2_ctl),
        .s2_addr   (s2_addr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // Both line stores share one word per column: bit 0 upper row, bit 1 middle row.
    bero_ram #(
        .WIDTH (bero_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s2_addr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shift the window, erode the center pixel, hold the result for the consumer.
    bero_win u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .s2_valid  (s2_valid),
        .s2_ctl    (s2_ctl),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_wdata (ram_wdata),
        .s2_fire   (s2_fire),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

endmodule
